// ===== src/rgb565_frame_packet_parser_defines.svh =====
// assertion macros for the checker file
`ifndef RGB565_FRAME_PACKET_PARSER_DEFINES_SVH
`define RGB565_FRAME_PACKET_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RFPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RFPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rfpp_pkg.sv =====
package rfpp_pkg;

  // packet layout and crc constants
  localparam int unsigned PosW        = 34;
  localparam int unsigned HeaderBytes = 17;
  localparam logic [31:0] CrcPoly     = 32'hEDB88320;
  localparam logic [31:0] CrcInit     = 32'hFFFFFFFF;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAGIC_WORD       = 1'b0,
    CFG_PROTOCOL_VERSION = 1'b1
  } cfg_idx_t;

  // packet status codes
  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_MAGIC     = 3'd2,
    VERDICT_VERSION   = 3'd3,
    VERDICT_ZERO_DIM  = 3'd4,
    VERDICT_TRUNCATED = 3'd5,
    VERDICT_CRC       = 3'd6
  } verdict_t;

  // one result beat
  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_value;
    logic        verdict_valid;
    logic [2:0]  verdict;
    logic [31:0] frame_number;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        last_result;
  } result_t;

  // up to two results written to the result queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = (acc >> 1) ^ (acc[0] ? CrcPoly : 32'd0);
    end
    return acc;
  endfunction

endpackage

// ===== src/rfpp_if.sv =====
// input byte channel
interface rfpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

// result channel
interface rfpp_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [15:0] pixel_value;
  logic        verdict_valid;
  logic [2:0]  verdict;
  logic [31:0] frame_number;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic        last_result;

  modport source (
    output valid, output pixel_valid, output pixel_value, output verdict_valid,
    output verdict, output frame_number, output frame_width, output frame_height,
    output last_result, input ready
  );
  modport sink (
    input valid, input pixel_valid, input pixel_value, input verdict_valid,
    input verdict, input frame_number, input frame_width, input frame_height,
    input last_result, output ready
  );
endinterface

// ===== src/rfpp_core.sv =====
module rfpp_core import rfpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [7:0]  in_byte,
  input  logic        in_eop,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        stg_busy,
  output push_t       push
);

  // configuration
  logic [31:0] magic_r;
  logic [7:0]  version_r;

  // input stage
  logic        stg_valid_r;
  logic [7:0]  stg_byte_r;
  logic        stg_eop_r;

  // per-packet state
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [2:0]      herr_r, herr_nxt;
  logic [31:0]     fid_r, fid_nxt;
  logic [15:0]     wid_r, wid_nxt;
  logic [15:0]     hgt_r, hgt_nxt;
  logic [31:0]     ecrc_r, ecrc_nxt;
  logic [PosW-1:0] plen_r, plen_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic [7:0]      lowb_r, lowb_nxt;

  logic [7:0]      b;
  logic [7:0]      magic_byte;
  logic [31:0]     area;
  logic [PosW-1:0] pay_off;
  logic            in_payload;
  logic            pix;
  logic            trunc;
  logic [2:0]      verdict;
  result_t         pix_res;
  result_t         ver_res;

  assign b          = stg_byte_r;
  assign magic_byte = 8'(magic_r >> {pos_r[1:0], 3'b000});
  assign area       = wid_r * hgt_r;
  assign pay_off    = pos_r - PosW'(HeaderBytes);
  assign in_payload = (pos_r >= PosW'(HeaderBytes)) && (herr_r == VERDICT_OK)
                      && (pay_off < plen_r);
  assign stg_busy   = stg_valid_r;

  // header capture, crc and pixel pairing
  always_comb begin
    pos_nxt  = pos_r;
    herr_nxt = herr_r;
    fid_nxt  = fid_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    ecrc_nxt = ecrc_r;
    plen_nxt = plen_r;
    crc_nxt  = crc_r;
    lowb_nxt = lowb_r;
    pix      = 1'b0;
    if (stg_valid_r) begin
      if (pos_r < PosW'(HeaderBytes)) begin
        case (pos_r[4:0])
          5'd0, 5'd1, 5'd2, 5'd3: begin
            if (b != magic_byte && herr_r == VERDICT_OK) herr_nxt = VERDICT_MAGIC;
          end
          5'd4: begin
            if (b != version_r && herr_r == VERDICT_OK) herr_nxt = VERDICT_VERSION;
          end
          5'd5:  fid_nxt[7:0]    = b;
          5'd6:  fid_nxt[15:8]   = b;
          5'd7:  fid_nxt[23:16]  = b;
          5'd8:  fid_nxt[31:24]  = b;
          5'd9:  wid_nxt[7:0]    = b;
          5'd10: wid_nxt[15:8]   = b;
          5'd11: hgt_nxt[7:0]    = b;
          5'd12: hgt_nxt[15:8]   = b;
          5'd13: ecrc_nxt[7:0]   = b;
          5'd14: ecrc_nxt[15:8]  = b;
          5'd15: ecrc_nxt[23:16] = b;
          5'd16: begin
            ecrc_nxt[31:24] = b;
            plen_nxt        = {1'b0, area, 1'b0};
          end
          default: ;
        endcase
      end else if (in_payload) begin
        crc_nxt = crc_byte(crc_r, b);
        if (pos_r[0]) lowb_nxt = b;
        else          pix      = 1'b1;
      end
      if (!(&pos_r)) pos_nxt = pos_r + PosW'(1);
    end
  end

  // status, in priority order, from the state after this beat
  assign trunc = (pos_r == PosW'(HeaderBytes - 1)) ||
                 ({1'b0, pos_r} < ({1'b0, plen_r} + (PosW + 1)'(HeaderBytes - 1)));

  always_comb begin
    if (pos_r < PosW'(HeaderBytes - 1))           verdict = VERDICT_SHORT;
    else if (herr_nxt != VERDICT_OK)              verdict = herr_nxt;
    else if (wid_nxt == 16'd0 || hgt_nxt == 16'd0) verdict = VERDICT_ZERO_DIM;
    else if (trunc)                               verdict = VERDICT_TRUNCATED;
    else if (ecrc_nxt != 32'd0 && (crc_nxt ^ CrcInit) != ecrc_nxt)
                                                  verdict = VERDICT_CRC;
    else                                          verdict = VERDICT_OK;
  end

  // result beats
  always_comb begin
    pix_res               = '0;
    pix_res.pixel_valid   = 1'b1;
    pix_res.pixel_value   = {b, lowb_r};
    pix_res.last_result   = !stg_eop_r;

    ver_res               = '0;
    ver_res.verdict_valid = 1'b1;
    ver_res.verdict       = verdict;
    ver_res.frame_number  = fid_nxt;
    ver_res.frame_width   = wid_nxt;
    ver_res.frame_height  = hgt_nxt;
    ver_res.last_result   = 1'b1;

    push.count  = stg_valid_r ? ({1'b0, pix} + {1'b0, stg_eop_r}) : 2'd0;
    push.first  = pix ? pix_res : ver_res;
    push.second = ver_res;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_WORD:       magic_r   <= cfg_wdata;
        CFG_PROTOCOL_VERSION: version_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_byte;
      stg_eop_r  <= in_eop;
    end
  end

  // packet state, back to reset values after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (stg_valid_r && stg_eop_r)) begin
      pos_r  <= '0;
      herr_r <= VERDICT_OK;
      fid_r  <= '0;
      wid_r  <= '0;
      hgt_r  <= '0;
      ecrc_r <= '0;
      plen_r <= '0;
      crc_r  <= CrcInit;
      lowb_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      herr_r <= herr_nxt;
      fid_r  <= fid_nxt;
      wid_r  <= wid_nxt;
      hgt_r  <= hgt_nxt;
      ecrc_r <= ecrc_nxt;
      plen_r <= plen_nxt;
      crc_r  <= crc_nxt;
      lowb_r <= lowb_nxt;
    end
  end

endmodule

// ===== src/rfpp_result_fifo.sv =====
module rfpp_result_fifo import rfpp_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  push_t                      push,
  input  logic                       pop,
  output result_t                    head,
  output logic                       head_valid,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int unsigned PW = $clog2(DEPTH);

  result_t        mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.count);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW + 1)'(push.count) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) mem_r[wr_ptr_r + PW'(1)] <= push.second;
  end

endmodule

// ===== src/rgb565_frame_packet_parser.sv =====
// path: an accepted byte passes the input stage register, then the result queue
// throughput: one byte per cycle while the queue has room; results leave one per
//   cycle while out_bus.ready is high; a packet-ending byte that completes a pixel
//   gives two results; the crc over a byte is combinational
// reset: synchronous active-low rst_n clears config to zero, packet state, crc to all
//   ones, and empties the stage and the result queue
module rgb565_frame_packet_parser import rfpp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  cfg_idx_t     cfg_index,
  input  logic [31:0]  cfg_wdata,
  rfpp_in_if.sink      in_bus,
  rfpp_out_if.source   out_bus
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH) + 1;

  logic          stg_busy;
  push_t         push;
  result_t       head;
  logic          head_valid;
  logic [CW-1:0] count;
  logic          in_take;
  logic          pop;
  logic [CW:0]   reserved;

  // room for two results of the staged beat and two of the next one
  assign reserved     = {1'b0, count} + {{(CW - 1){1'b0}}, stg_busy, 1'b0};
  assign in_bus.ready = (reserved <= (CW + 1)'(FIFO_DEPTH - 2));
  assign in_take      = in_bus.valid && in_bus.ready;
  assign pop          = head_valid && out_bus.ready;

  rfpp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_byte   (in_bus.packet_byte),
    .in_eop    (in_bus.end_of_packet),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stg_busy  (stg_busy),
    .push      (push)
  );

  rfpp_result_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (count)
  );

  // result port
  assign out_bus.valid         = head_valid;
  assign out_bus.pixel_valid   = head.pixel_valid;
  assign out_bus.pixel_value   = head.pixel_value;
  assign out_bus.verdict_valid = head.verdict_valid;
  assign out_bus.verdict       = head.verdict;
  assign out_bus.frame_number  = head.frame_number;
  assign out_bus.frame_width   = head.frame_width;
  assign out_bus.frame_height  = head.frame_height;
  assign out_bus.last_result   = head.last_result;

endmodule

// ===== src/rfpp_checker.sv =====
`include "rgb565_frame_packet_parser_defines.svh"

module rfpp_checker import rfpp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_pixel_valid,
  input logic       out_verdict_valid,
  input logic [2:0] out_verdict,
  input logic       out_last_result
);

  // a beat carries exactly one of pixel or verdict
  `RFPP_ASSERT_NOW(a_one_kind, out_valid, out_pixel_valid != out_verdict_valid, "beat kind not unique")

  // a verdict always closes the results of its byte
  `RFPP_ASSERT_NOW(a_verdict_last, out_valid && out_verdict_valid, out_last_result, "verdict not last")

  // status codes stay in the defined range
  `RFPP_ASSERT_NOW(a_verdict_code, out_valid && out_verdict_valid, out_verdict <= VERDICT_CRC, "bad status code")

  // a stalled result beat is not withdrawn
  `RFPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

endmodule

bind rgb565_frame_packet_parser rfpp_checker u_rfpp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_pixel_valid   (out_bus.pixel_valid),
  .out_verdict_valid (out_bus.verdict_valid),
  .out_verdict       (out_bus.verdict),
  .out_last_result   (out_bus.last_result)
);
